FILE: hdl/psk_pkg.sv
// Package for the prime candidate sieve skipper: field widths, action codes,
// the structs passed between lane cells, loader and top level, and tree helpers.
// Depends on nothing.
`default_nettype none

package psk_pkg;

  localparam int ACTION_W   = 2;
  localparam int LANE_W     = 8;
  localparam int FIELD_W    = 17;
  localparam int COUNT_W    = 16;
  localparam int LANE_SPAN  = 2 ** LANE_W;
  localparam int TREE_FANIN = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD      = 2'd0,
    ACT_SEEK      = 2'd1,
    ACT_STEP_SEEK = 2'd2,
    ACT_NOP       = 2'd3
  } action_t;

  typedef struct packed {
    logic step;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic              valid;
    logic [LANE_W-1:0] lane;
  } lane_wr_t;

  function automatic int level_width(int n, int lv);
    int w;
    w = n;
    for (int i = 0; i < lv; i++) begin
      w = (w + TREE_FANIN - 1) / TREE_FANIN;
    end
    return w;
  endfunction

  function automatic int tree_levels(int n);
    int w;
    int lv;
    lv = 1;
    w  = (n + TREE_FANIN - 1) / TREE_FANIN;
    while (w > 1) begin
      w  = (w + TREE_FANIN - 1) / TREE_FANIN;
      lv = lv + 1;
    end
    return lv;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/psk_cmd_if.sv
// Command channel of the prime candidate sieve skipper: handshake and the
// fields of one command transaction. Depends on psk_pkg.
`default_nettype none

interface psk_cmd_if;
  import psk_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [LANE_W-1:0]   lane_index;
  logic [FIELD_W-1:0]  lane_prime_value;
  logic [FIELD_W-1:0]  start_residue;

  modport source (
    output valid, action, lane_index, lane_prime_value, start_residue,
    input  ready
  );

  modport sink (
    input  valid, action, lane_index, lane_prime_value, start_residue,
    output ready
  );

endinterface

`default_nettype wire

FILE: hdl/psk_rsp_if.sv
// Result channel of the prime candidate sieve skipper: handshake and the
// fields of one result transaction. Depends on psk_pkg.
`default_nettype none

interface psk_rsp_if;
  import psk_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] skip_count;
  logic               count_saturated;

  modport source (
    output valid, skip_count, count_saturated,
    input  ready
  );

  modport sink (
    input  valid, skip_count, count_saturated,
    output ready
  );

endinterface

`default_nettype wire

FILE: hdl/psk_cell.sv
// One sieve lane: holds a prime and the step offset modulo that prime, and
// flags when an active lane sits at offset zero. Depends on psk_pkg.
`default_nettype none

module psk_cell #(
  parameter int PRIME_BITS = 17
) (
  input  logic                   clk,
  input  logic                   rst,
  input  psk_pkg::cell_ctrl_t    ctrl,
  input  logic [PRIME_BITS-1:0]  load_prime,
  input  logic [PRIME_BITS-1:0]  load_offset,
  output logic                   zero
);

  logic [PRIME_BITS-1:0] prime;
  logic [PRIME_BITS-1:0] offset;
  logic [PRIME_BITS:0]   offset_inc;
  logic                  wrap;

  assign offset_inc = {1'b0, offset} + {{PRIME_BITS{1'b0}}, 1'b1};
  assign wrap       = offset_inc >= {1'b0, prime};

  always_ff @(posedge clk) begin
    if (rst) begin
      prime  <= '0;
      offset <= '0;
      zero   <= 1'b0;
    end else if (ctrl.load) begin
      prime  <= load_prime;
      offset <= load_offset;
      zero   <= (load_prime != '0) && (load_offset == '0);
    end else if (ctrl.step) begin
      if (prime == '0) begin
        offset <= '0;
        zero   <= 1'b0;
      end else if (wrap) begin
        offset <= '0;
        zero   <= 1'b1;
      end else begin
        offset <= offset_inc[PRIME_BITS-1:0];
        zero   <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/psk_or_tree.sv
// Registered OR reduction of the lane zero flags, sixteen inputs per node.
// Depends on psk_pkg.
`default_nettype none

module psk_or_tree #(
  parameter int NUM_LANES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [NUM_LANES-1:0] flags,
  output logic                 any
);
  import psk_pkg::*;

  localparam int LEVELS = tree_levels(NUM_LANES);

  logic [NUM_LANES-1:0] lvl [0:LEVELS];

  assign lvl[0] = flags;

  for (genvar l = 1; l <= LEVELS; l++) begin : g_level
    localparam int W_IN  = level_width(NUM_LANES, l - 1);
    localparam int W_OUT = level_width(NUM_LANES, l);

    logic [NUM_LANES-1:0] nxt;

    always_comb begin
      nxt = '0;
      for (int j = 0; j < W_OUT; j++) begin
        for (int k = 0; k < TREE_FANIN; k++) begin
          if (TREE_FANIN * j + k < W_IN) begin
            nxt[j] = nxt[j] | lvl[l-1][TREE_FANIN * j + k];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        lvl[l] <= '0;
      end else begin
        lvl[l] <= nxt;
      end
    end
  end

  assign any = lvl[LEVELS][0];

endmodule

`default_nettype wire

FILE: hdl/psk_loader.sv
// Lane loader: reduces the start residue modulo the prime one bit a cycle,
// halves it into a step offset and issues the write to the chosen lane.
// Depends on psk_pkg.
`default_nettype none

module psk_loader #(
  parameter int PRIME_BITS = 17
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [psk_pkg::LANE_W-1:0]   lane,
  input  logic [PRIME_BITS-1:0]        prime,
  input  logic [PRIME_BITS-1:0]        residue,
  output psk_pkg::lane_wr_t            wr,
  output logic [PRIME_BITS-1:0]        wr_prime,
  output logic [PRIME_BITS-1:0]        wr_offset
);
  import psk_pkg::*;

  localparam int CW = $clog2(PRIME_BITS);

  typedef enum logic [1:0] {
    L_IDLE,
    L_DIV,
    L_FIX,
    L_WRITE
  } lstate_t;

  lstate_t               state;
  logic [CW-1:0]         cnt;
  logic [PRIME_BITS-1:0] p;
  logic [PRIME_BITS-1:0] dividend;
  logic [PRIME_BITS-1:0] rem;
  logic [LANE_W-1:0]     lane_q;
  logic [PRIME_BITS:0]   trial;
  logic [PRIME_BITS:0]   sum;

  assign trial = {rem, dividend[PRIME_BITS-1]};
  assign sum   = {1'b0, rem} + {1'b0, p};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      unique case (state)
        L_IDLE: begin
          if (start) begin
            p        <= prime;
            dividend <= residue;
            rem      <= '0;
            lane_q   <= lane;
            cnt      <= CW'(PRIME_BITS - 1);
            state    <= L_DIV;
          end
        end
        L_DIV: begin
          if (trial >= {1'b0, p}) begin
            rem <= PRIME_BITS'(trial - {1'b0, p});
          end else begin
            rem <= trial[PRIME_BITS-1:0];
          end
          dividend <= dividend << 1;
          if (cnt == '0) begin
            state <= L_FIX;
          end else begin
            cnt <= cnt - CW'(1);
          end
        end
        L_FIX: begin
          if (p == '0) begin
            rem <= '0;
          end else if (rem[0]) begin
            rem <= sum[PRIME_BITS:1];
          end else begin
            rem <= rem >> 1;
          end
          state <= L_WRITE;
        end
        L_WRITE: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

  assign wr.valid  = (state == L_WRITE);
  assign wr.lane   = lane_q;
  assign wr_prime  = p;
  assign wr_offset = rem;

endmodule

`default_nettype wire

FILE: hdl/prime_candidate_sieve_skipper.sv
// Top level of the prime candidate sieve skipper: the row of lane cells, the
// zero-flag OR tree, the lane loader and the seek sequencer.
// Depends on psk_pkg, psk_cmd_if, psk_rsp_if, psk_cell, psk_or_tree, psk_loader.
//
// A row of NUM_LANES cells each holds a small prime and the candidate's offset
// modulo it; all cells step together in the same cycle. A load transaction runs
// the bit-serial remainder in the loader, then writes the chosen lane, and
// gives no result. A seek waits for the registered OR tree over the zero flags,
// whose depth L is ceil(log16(NUM_LANES)) (2 for 256 lanes), before each
// decision to step again or to offer its result.
// One command is worked on at a time; a finished result waits in an output
// register while the next command is taken.
`default_nettype none

module prime_candidate_sieve_skipper #(
  parameter int NUM_LANES  = 256,
  parameter int PRIME_BITS = 17
) (
  input  logic       clk,
  input  logic       rst,
  psk_cmd_if.sink    cmd,
  psk_rsp_if.source  rsp
);
  import psk_pkg::*;

  localparam int LEVELS = tree_levels(NUM_LANES);
  localparam int WAIT_W = $clog2(LEVELS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_WAIT,
    S_DONE
  } state_t;

  state_t                         state;
  logic [WAIT_W-1:0]              wait_cnt;
  logic [COUNT_W-1:0]             count;
  logic                           rsp_valid;
  logic [COUNT_W-1:0]             rsp_count;
  logic                           rsp_sat;
  action_t                        act;
  logic                           accept;
  logic                           load_start;
  logic                           settled;
  logic                           step;
  logic                           any_zero;
  lane_wr_t                       wr;
  logic [FIELD_W+PRIME_BITS-1:0]  prime_wide;
  logic [FIELD_W+PRIME_BITS-1:0]  residue_wide;
  logic [PRIME_BITS-1:0]          prime_in;
  logic [PRIME_BITS-1:0]          residue_in;
  logic [PRIME_BITS-1:0]          wr_prime;
  logic [PRIME_BITS-1:0]          wr_offset;
  logic [NUM_LANES-1:0]           zero_flags;

  assign cmd.ready  = (state == S_IDLE);
  assign accept     = cmd.valid && cmd.ready;
  assign act        = action_t'(cmd.action);
  assign load_start = accept && (act == ACT_LOAD);
  assign settled    = (state == S_WAIT) && (wait_cnt == '0);
  assign step       = (accept && (act == ACT_STEP_SEEK))
                    || (settled && any_zero && (count != COUNT_MAX));

  assign prime_wide   = {{PRIME_BITS{1'b0}}, cmd.lane_prime_value};
  assign residue_wide = {{PRIME_BITS{1'b0}}, cmd.start_residue};
  assign prime_in     = prime_wide[PRIME_BITS-1:0];
  assign residue_in   = residue_wide[PRIME_BITS-1:0];

  psk_loader #(
    .PRIME_BITS (PRIME_BITS)
  ) u_loader (
    .clk       (clk),
    .rst       (rst),
    .start     (load_start),
    .lane      (cmd.lane_index),
    .prime     (prime_in),
    .residue   (residue_in),
    .wr        (wr),
    .wr_prime  (wr_prime),
    .wr_offset (wr_offset)
  );

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_cell
    cell_ctrl_t ctrl;

    assign ctrl.step = step;

    if (i < LANE_SPAN) begin : g_loadable
      assign ctrl.load = wr.valid && (wr.lane == LANE_W'(i));
    end else begin : g_fixed
      assign ctrl.load = 1'b0;
    end

    psk_cell #(
      .PRIME_BITS (PRIME_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .load_prime  (wr_prime),
      .load_offset (wr_offset),
      .zero        (zero_flags[i])
    );
  end

  psk_or_tree #(
    .NUM_LANES (NUM_LANES)
  ) u_tree (
    .clk   (clk),
    .rst   (rst),
    .flags (zero_flags),
    .any   (any_zero)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wait_cnt  <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (act)
              ACT_LOAD: begin
                state <= S_LOAD;
              end
              ACT_SEEK: begin
                count    <= '0;
                wait_cnt <= WAIT_W'(LEVELS);
                state    <= S_WAIT;
              end
              ACT_STEP_SEEK: begin
                count    <= COUNT_W'(1);
                wait_cnt <= WAIT_W'(LEVELS);
                state    <= S_WAIT;
              end
              ACT_NOP: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_LOAD: begin
          if (wr.valid) begin
            state <= S_IDLE;
          end
        end
        S_WAIT: begin
          if (!settled) begin
            wait_cnt <= wait_cnt - WAIT_W'(1);
          end else if (step) begin
            count    <= count + COUNT_W'(1);
            wait_cnt <= WAIT_W'(LEVELS);
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_count <= count;
            rsp_sat   <= (count == COUNT_MAX);
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign rsp.valid           = rsp_valid;
  assign rsp.skip_count      = rsp_count;
  assign rsp.count_saturated = rsp_sat;

  a_no_step_on_write: assert property (@(posedge clk) disable iff (rst)
    !(step && wr.valid))
    else $error("Lanes stepped while a lane write was in flight.");

  a_write_only_loading: assert property (@(posedge clk) disable iff (rst)
    wr.valid |-> (state == S_LOAD))
    else $error("Lane write issued outside a load transaction.");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |=> ((state != S_WAIT) || (count >= $past(count))))
    else $error("Step count fell during a seek.");

  a_sat_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_sat == (rsp_count == COUNT_MAX)))
    else $error("Saturation flag disagrees with the reported count.");

endmodule

`default_nettype wire

FILE: verif/tb_prime_candidate_sieve_skipper.sv
// Self-checking testbench for prime_candidate_sieve_skipper: lane loads and seeks
// are driven, and every skip result is checked against an in-bench sieve model.
// Depends on psk_pkg, psk_cmd_if, psk_rsp_if and the block under test.
`timescale 1ns / 1ps

module tb_prime_candidate_sieve_skipper;
  import psk_pkg::*;

  typedef struct packed {
    action_t              act;
    logic [LANE_W-1:0]    lane;
    logic [FIELD_W-1:0]   prime;
    logic [FIELD_W-1:0]   residue;
  } sieve_cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0] skip_count;
    logic               count_saturated;
  } skip_result_t;

  logic clk = 1'b0;
  logic rst;

  psk_cmd_if cmd_ch ();
  psk_rsp_if rsp_ch ();

  prime_candidate_sieve_skipper dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  always #1 clk = ~clk;

  sieve_cmd_t   pending_cmds[$];
  skip_result_t expected_skips[$];

  logic [FIELD_W-1:0] sieve_prime [LANE_SPAN];
  logic [FIELD_W-1:0] sieve_offset[LANE_SPAN];

  int send_idle_pct = 27;
  int recv_idle_pct = 75;
  int commands_taken = 0;
  int mismatches = 0;

  function automatic void sieve_load(logic [LANE_W-1:0] lane, logic [FIELD_W-1:0] prime,
                                     logic [FIELD_W-1:0] residue);
    int p;
    int r;
    p = int'(prime);
    r = int'(residue);
    sieve_prime[lane] = prime;
    if (p == 0) begin
      sieve_offset[lane] = '0;
    end else begin
      r = r % p;
      r = (r % 2 == 1) ? (r + p) / 2 : r / 2;
      sieve_offset[lane] = r[FIELD_W-1:0];
    end
  endfunction

  function automatic void advance_candidate();
    for (int i = 0; i < LANE_SPAN; i++) begin
      if (sieve_prime[i] == '0) begin
        sieve_offset[i] = '0;
      end else if (int'(sieve_offset[i]) + 1 >= int'(sieve_prime[i])) begin
        sieve_offset[i] = '0;
      end else begin
        sieve_offset[i] = sieve_offset[i] + 1'b1;
      end
    end
  endfunction

  function automatic bit candidate_divisible();
    for (int i = 0; i < LANE_SPAN; i++) begin
      if (sieve_prime[i] != '0 && sieve_offset[i] == '0) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic skip_result_t seek_skip(action_t act);
    int steps;
    skip_result_t res;
    steps = 0;
    if (act == ACT_STEP_SEEK) begin
      advance_candidate();
      steps = 1;
    end
    while (steps < int'(COUNT_MAX) && candidate_divisible()) begin
      advance_candidate();
      steps++;
    end
    res.skip_count      = steps[COUNT_W-1:0];
    res.count_saturated = (steps >= int'(COUNT_MAX));
    return res;
  endfunction

  task automatic queue_cmd(action_t act, int lane, int prime, int residue);
    sieve_cmd_t c;
    c.act     = act;
    c.lane    = lane[LANE_W-1:0];
    c.prime   = prime[FIELD_W-1:0];
    c.residue = residue[FIELD_W-1:0];
    pending_cmds.push_back(c);
  endtask

  always @(posedge clk) begin
    sieve_cmd_t c;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        commands_taken++;
        case (action_t'(cmd_ch.action))
          ACT_LOAD: begin
            sieve_load(cmd_ch.lane_index, cmd_ch.lane_prime_value, cmd_ch.start_residue);
          end
          ACT_SEEK, ACT_STEP_SEEK: begin
            expected_skips.push_back(seek_skip(action_t'(cmd_ch.action)));
          end
          default: begin
          end
        endcase
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          c = pending_cmds.pop_front();
          cmd_ch.valid            <= 1'b1;
          cmd_ch.action           <= c.act;
          cmd_ch.lane_index       <= c.lane;
          cmd_ch.lane_prime_value <= c.prime;
          cmd_ch.start_residue    <= c.residue;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    skip_result_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_skips.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected skip result: count %0d saturated %0b",
                     rsp_ch.skip_count, rsp_ch.count_saturated);
          end
          mismatches++;
        end else begin
          want = expected_skips.pop_front();
          if (rsp_ch.skip_count !== want.skip_count ||
              rsp_ch.count_saturated !== want.count_saturated) begin
            if (mismatches < 10) begin
              $display("skip mismatch: expected count %0d saturated %0b, got count %0d saturated %0b",
                       want.skip_count, want.count_saturated,
                       rsp_ch.skip_count, rsp_ch.count_saturated);
            end
            mismatches++;
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    int home_prime[LANE_SPAN];
    int cand;
    int found;
    bit is_prime;
    int items;
    int batch;
    int lane;
    int pick;
    int total;

    rst                     = 1'b1;
    cmd_ch.valid            = 1'b0;
    cmd_ch.action           = ACT_NOP;
    cmd_ch.lane_index       = '0;
    cmd_ch.lane_prime_value = '0;
    cmd_ch.start_residue    = '0;
    rsp_ch.ready            = 1'b0;
    for (int i = 0; i < LANE_SPAN; i++) begin
      sieve_prime[i]  = '0;
      sieve_offset[i] = '0;
    end

    // Each lane has its own odd prime, so random residues can never cover every candidate.
    cand  = 3;
    found = 0;
    while (found < LANE_SPAN) begin
      is_prime = 1'b1;
      for (int d = 3; d * d <= cand; d += 2) begin
        if (cand % d == 0) is_prime = 1'b0;
      end
      if (is_prime) begin
        home_prime[found] = cand;
        found++;
      end
      cand += 2;
    end

    queue_cmd(ACT_SEEK, 0, 0, 0);
    queue_cmd(ACT_STEP_SEEK, 0, 0, 0);
    queue_cmd(ACT_LOAD, 0, 3, 0);
    queue_cmd(ACT_SEEK, 0, 0, 0);
    queue_cmd(ACT_LOAD, 255, 131071, 131071);
    queue_cmd(ACT_SEEK, 0, 0, 0);
    queue_cmd(ACT_LOAD, 1, 2, 1);
    queue_cmd(ACT_LOAD, 2, 4, 2);
    queue_cmd(ACT_LOAD, 3, 5, 3);
    queue_cmd(ACT_LOAD, 4, 7, 100);
    queue_cmd(ACT_LOAD, 5, 0, 77);
    queue_cmd(ACT_NOP, 170, 85, 43690);
    queue_cmd(ACT_STEP_SEEK, 0, 0, 0);
    queue_cmd(ACT_SEEK, 0, 0, 0);
    queue_cmd(ACT_LOAD, 6, 1, 0);
    queue_cmd(ACT_SEEK, 0, 0, 0);
    queue_cmd(ACT_STEP_SEEK, 0, 0, 0);

    for (int i = 0; i < LANE_SPAN; i++) begin
      queue_cmd(ACT_LOAD, i, home_prime[i], $urandom_range(home_prime[i] - 1));
    end

    items = pending_cmds.size();
    while (items < 1650) begin
      batch = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      for (int k = 0; k < batch; k++) begin
        lane = $urandom_range(LANE_SPAN - 1);
        pick = $urandom_range(99);
        if (pick < 80) begin
          queue_cmd(ACT_LOAD, lane, home_prime[lane], $urandom_range(home_prime[lane] - 1));
        end else if (pick < 88) begin
          queue_cmd(ACT_LOAD, lane, home_prime[lane], $urandom_range(131071));
        end else if (pick < 94) begin
          queue_cmd(ACT_LOAD, lane, 0, $urandom_range(131071));
        end else begin
          queue_cmd(ACT_LOAD, lane, $urandom_range(2048, 131071), $urandom_range(131071));
        end
        items++;
      end
      if ($urandom_range(19) == 0) begin
        queue_cmd(ACT_NOP, $urandom_range(255), $urandom_range(131071), $urandom_range(131071));
      end
      batch = $urandom_range(1, 6);
      for (int k = 0; k < batch; k++) begin
        queue_cmd(action_t'($urandom_range(ACT_SEEK, ACT_STEP_SEEK)), $urandom_range(255),
                  $urandom_range(131071), $urandom_range(131071));
        items++;
      end
    end
    total = pending_cmds.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    wait (commands_taken >= total / 3);
    send_idle_pct = 75;
    recv_idle_pct = 27;
    wait (commands_taken >= 2 * total / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;

    while (pending_cmds.size() != 0 || cmd_ch.valid) @(posedge clk);
    while (expected_skips.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (mismatches == 0 && expected_skips.size() == 0) begin
      $display("tb_prime_candidate_sieve_skipper passed");
    end else begin
      $display("tb_prime_candidate_sieve_skipper failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb_prime_candidate_sieve_skipper failed");
    $finish;
  end

endmodule

FILE: sim.f
hdl/psk_pkg.sv
hdl/psk_cmd_if.sv
hdl/psk_rsp_if.sv
hdl/psk_cell.sv
hdl/psk_or_tree.sv
hdl/psk_loader.sv
hdl/prime_candidate_sieve_skipper.sv
verif/tb_prime_candidate_sieve_skipper.sv
